[rtl/cia_pkg.sv]
// ----------------------------------------------------------------------------
// cia_pkg: shared types and constants
// Operation codes, result width and the control bundle that travels with
// each request along the datapath.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int RES_WIDTH = 33;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       dz;
    logic       neg_r;
    logic       neg_i;
  } ctl_t;

endpackage

[rtl/cia_front.sv]
// ----------------------------------------------------------------------------
// cia_front: product and combine stages
// Stage one forms the partial products, squares and sum or difference;
// stage two forms the complex product, the division numerators and divisor.
// ----------------------------------------------------------------------------
module cia_front
  import cia_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       operation,
  input  logic signed [OPERAND_WIDTH-1:0]  a_real,
  input  logic signed [OPERAND_WIDTH-1:0]  a_imag,
  input  logic signed [OPERAND_WIDTH-1:0]  b_real,
  input  logic signed [OPERAND_WIDTH-1:0]  b_imag,
  output logic                             valid_o,
  input  logic                             ready_i,
  output ctl_t                             ctl_o,
  output logic [2*OPERAND_WIDTH-1:0]       num_r_o,
  output logic [2*OPERAND_WIDTH-1:0]       num_i_o,
  output logic [2*OPERAND_WIDTH-1:0]       den_o,
  output logic signed [RES_WIDTH-1:0]      res_r_o,
  output logic signed [RES_WIDTH-1:0]      res_i_o
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int EW = (PW + 1 > RES_WIDTH) ? PW + 1 : RES_WIDTH;

  // stage one registers
  logic                 v1;
  logic [1:0]           op1;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, s_rr, s_ii;
  logic signed [W:0]    as_r, as_i;
  logic                 rdy1, rdy2;

  // stage two registers
  logic                 v2;
  assign rdy2     = !v2 || ready_i;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // stage one: products and add or subtract
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
    if (rdy1 && in_valid) begin
      op1  <= operation;
      p_rr <= a_real * b_real;
      p_ii <= a_imag * b_imag;
      p_ri <= a_real * b_imag;
      p_ir <= a_imag * b_real;
      s_rr <= b_real * b_real;
      s_ii <= b_imag * b_imag;
      if (operation == OP_SUB) begin
        as_r <= (W+1)'(a_real) - (W+1)'(b_real);
        as_i <= (W+1)'(a_imag) - (W+1)'(b_imag);
      end else begin
        as_r <= (W+1)'(a_real) + (W+1)'(b_real);
        as_i <= (W+1)'(a_imag) + (W+1)'(b_imag);
      end
    end
  end

  // stage two combine
  logic signed [PW:0]   mr, mi, nr, ni;
  logic signed [EW-1:0] mr_ext, mi_ext;
  logic [PW-1:0]        den;
  logic [PW:0]          nr_abs, ni_abs;

  assign mr     = (PW+1)'(p_rr) - (PW+1)'(p_ii);
  assign mi     = (PW+1)'(p_ri) + (PW+1)'(p_ir);
  assign nr     = (PW+1)'(p_rr) + (PW+1)'(p_ii);
  assign ni     = (PW+1)'(p_ir) - (PW+1)'(p_ri);
  assign mr_ext = EW'(mr);
  assign mi_ext = EW'(mi);
  assign den    = $unsigned(s_rr) + $unsigned(s_ii);
  assign nr_abs = nr[PW] ? $unsigned(-nr) : $unsigned(nr);
  assign ni_abs = ni[PW] ? $unsigned(-ni) : $unsigned(ni);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      ctl_o.op    <= op1;
      ctl_o.dz    <= (op1 == OP_DIV) && (den == '0);
      ctl_o.neg_r <= nr[PW];
      ctl_o.neg_i <= ni[PW];
      num_r_o     <= nr_abs[PW-1:0];
      num_i_o     <= ni_abs[PW-1:0];
      den_o       <= den;
      if (op1 == OP_MUL) begin
        res_r_o <= mr_ext[RES_WIDTH-1:0];
        res_i_o <= mi_ext[RES_WIDTH-1:0];
      end else begin
        res_r_o <= RES_WIDTH'(as_r);
        res_i_o <= RES_WIDTH'(as_i);
      end
    end
  end

  assign valid_o = v2;

endmodule

[rtl/cia_cell.sv]
// ----------------------------------------------------------------------------
// cia_cell: one restoring division step
// Develops one quotient bit for both the real and the imaginary part and
// hands the request on to its neighbor.
// ----------------------------------------------------------------------------
module cia_cell
  import cia_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  ctl_t                         ctl_i,
  input  logic [2*OPERAND_WIDTH-1:0]   den_i,
  input  logic [2*OPERAND_WIDTH-1:0]   nq_r_i,
  input  logic [2*OPERAND_WIDTH-1:0]   nq_i_i,
  input  logic [2*OPERAND_WIDTH-1:0]   rem_r_i,
  input  logic [2*OPERAND_WIDTH-1:0]   rem_i_i,
  input  logic signed [RES_WIDTH-1:0]  res_r_i,
  input  logic signed [RES_WIDTH-1:0]  res_i_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output ctl_t                         ctl_o,
  output logic [2*OPERAND_WIDTH-1:0]   den_o,
  output logic [2*OPERAND_WIDTH-1:0]   nq_r_o,
  output logic [2*OPERAND_WIDTH-1:0]   nq_i_o,
  output logic [2*OPERAND_WIDTH-1:0]   rem_r_o,
  output logic [2*OPERAND_WIDTH-1:0]   rem_i_o,
  output logic signed [RES_WIDTH-1:0]  res_r_o,
  output logic signed [RES_WIDTH-1:0]  res_i_o
);

  localparam int PW = 2 * OPERAND_WIDTH;

  logic [PW:0] sr, si, dr, di;
  logic        ge_r, ge_i;

  // shift in next numerator bit and trial subtract
  assign sr   = {rem_r_i, nq_r_i[PW-1]};
  assign si   = {rem_i_i, nq_i_i[PW-1]};
  assign ge_r = sr >= {1'b0, den_i};
  assign ge_i = si >= {1'b0, den_i};
  assign dr   = ge_r ? sr - {1'b0, den_i} : sr;
  assign di   = ge_i ? si - {1'b0, den_i} : si;

  assign ready_o = !valid_o || ready_i;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (ready_o) begin
      valid_o <= valid_i;
    end
    if (ready_o && valid_i) begin
      ctl_o   <= ctl_i;
      den_o   <= den_i;
      nq_r_o  <= {nq_r_i[PW-2:0], ge_r};
      nq_i_o  <= {nq_i_i[PW-2:0], ge_i};
      rem_r_o <= dr[PW-1:0];
      rem_i_o <= di[PW-1:0];
      res_r_o <= res_r_i;
      res_i_o <= res_i_i;
    end
  end

endmodule

[rtl/complex_integer_alu.sv]
// ----------------------------------------------------------------------------
// complex_integer_alu: Gaussian integer add, subtract, multiply, divide
// Pipelined complex arithmetic with a row of restoring divider cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one request: operation and the
//   operand parts a_real, a_imag, b_real, b_imag (OPERAND_WIDTH bits each).
//   Output channel out_valid/out_ready returns res_real, res_imag (33 bits)
//   and div_by_zero, one result per request, in request order.
//   Every operation passes the same path: two product/combine stages, one
//   divider cell per quotient bit, and the output register.
//   Throughput is one request per cycle while the receiver keeps out_ready
//   high; every stage holds one request.
//   A stalled receiver holds the output register; upstream stages keep
//   filling any empty slot, so in_ready drops only once the whole path is
//   full. Reset empties the path; no request is in flight afterwards.
//   Divide truncates toward zero; a zero divisor gives zero parts and sets
//   div_by_zero.
// ----------------------------------------------------------------------------
module complex_integer_alu
  import cia_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       operation,
  input  logic signed [OPERAND_WIDTH-1:0]  a_real,
  input  logic signed [OPERAND_WIDTH-1:0]  a_imag,
  input  logic signed [OPERAND_WIDTH-1:0]  b_real,
  input  logic signed [OPERAND_WIDTH-1:0]  b_imag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [RES_WIDTH-1:0]      res_real,
  output logic signed [RES_WIDTH-1:0]      res_imag,
  output logic                             div_by_zero
);

  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int NC = PW;
  localparam int EW = (PW + 1 > RES_WIDTH) ? PW + 1 : RES_WIDTH;

  // chain links, index 0 feeds the first cell
  logic                 c_valid [NC+1];
  logic                 c_ready [NC+1];
  ctl_t                 c_ctl   [NC+1];
  logic [PW-1:0]        c_den   [NC+1];
  logic [PW-1:0]        c_nq_r  [NC+1];
  logic [PW-1:0]        c_nq_i  [NC+1];
  logic [PW-1:0]        c_rem_r [NC+1];
  logic [PW-1:0]        c_rem_i [NC+1];
  logic signed [RES_WIDTH-1:0] c_res_r [NC+1];
  logic signed [RES_WIDTH-1:0] c_res_i [NC+1];

  // product and combine stages
  cia_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .a_real    (a_real),
    .a_imag    (a_imag),
    .b_real    (b_real),
    .b_imag    (b_imag),
    .valid_o   (c_valid[0]),
    .ready_i   (c_ready[0]),
    .ctl_o     (c_ctl[0]),
    .num_r_o   (c_nq_r[0]),
    .num_i_o   (c_nq_i[0]),
    .den_o     (c_den[0]),
    .res_r_o   (c_res_r[0]),
    .res_i_o   (c_res_i[0])
  );

  assign c_rem_r[0] = '0;
  assign c_rem_i[0] = '0;

  // divider cells, one quotient bit each
  for (genvar k = 0; k < NC; k++) begin : g_cell
    cia_cell #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .valid_i (c_valid[k]),
      .ready_o (c_ready[k]),
      .ctl_i   (c_ctl[k]),
      .den_i   (c_den[k]),
      .nq_r_i  (c_nq_r[k]),
      .nq_i_i  (c_nq_i[k]),
      .rem_r_i (c_rem_r[k]),
      .rem_i_i (c_rem_i[k]),
      .res_r_i (c_res_r[k]),
      .res_i_i (c_res_i[k]),
      .valid_o (c_valid[k+1]),
      .ready_i (c_ready[k+1]),
      .ctl_o   (c_ctl[k+1]),
      .den_o   (c_den[k+1]),
      .nq_r_o  (c_nq_r[k+1]),
      .nq_i_o  (c_nq_i[k+1]),
      .rem_r_o (c_rem_r[k+1]),
      .rem_i_o (c_rem_i[k+1]),
      .res_r_o (c_res_r[k+1]),
      .res_i_o (c_res_i[k+1])
    );
  end

  // quotient sign and result select
  ctl_t                 fc;
  logic signed [EW-1:0] q_r, q_i;
  logic signed [RES_WIDTH-1:0] fin_r, fin_i;

  assign fc  = c_ctl[NC];
  assign q_r = fc.neg_r ? -EW'(c_nq_r[NC]) : EW'(c_nq_r[NC]);
  assign q_i = fc.neg_i ? -EW'(c_nq_i[NC]) : EW'(c_nq_i[NC]);

  always_comb begin
    case (fc.op)
      OP_DIV: begin
        fin_r = fc.dz ? '0 : q_r[RES_WIDTH-1:0];
        fin_i = fc.dz ? '0 : q_i[RES_WIDTH-1:0];
      end
      default: begin
        fin_r = c_res_r[NC];
        fin_i = c_res_i[NC];
      end
    endcase
  end

  // output register
  assign c_ready[NC] = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_ready[NC]) begin
      out_valid <= c_valid[NC];
    end
    if (c_ready[NC] && c_valid[NC]) begin
      res_real    <= fin_r;
      res_imag    <= fin_i;
      div_by_zero <= fc.dz;
    end
  end

endmodule

[rtl/cia_checker.sv]
// ----------------------------------------------------------------------------
// cia_checker: port-level checks
// Watches the top level ports for result hold, reset and divide flag rules.
// ----------------------------------------------------------------------------
module cia_checker
  import cia_pkg::*;
(
  input logic                             clk,
  input logic                             rst,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [RES_WIDTH-1:0]      res_real,
  input logic signed [RES_WIDTH-1:0]      res_imag,
  input logic                             div_by_zero
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_real) && $stable(res_imag)
      && $stable(div_by_zero))
    else $error("result changed while stalled");

  // path is empty right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // zero divisor gives zero parts
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_by_zero |-> res_real == '0 && res_imag == '0)
    else $error("nonzero result with zero divisor");

  // an empty path takes a request right after reset
  a_rdy: assert property (@(posedge clk) $past(rst) |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind complex_integer_alu cia_checker u_cia_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .res_real    (res_real),
  .res_imag    (res_imag),
  .div_by_zero (div_by_zero)
);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for complex_integer_alu
// A directed table of corner cases is sent first, then random Gaussian
// integer operands. The sender runs in bursts, the receiver stalls, and
// every result is compared with a typed expected value or a built-in predictor.
// ----------------------------------------------------------------------------
module tb;
  import cia_pkg::*;

  localparam int OW = 16;
  localparam int NUM_RANDOM = 950;
  localparam int DRAIN_CYCLES = 2 * OW + 10;
  localparam int IDLE_LIMIT = 4000;
  localparam int NUM_DIRECTED = 16;
  localparam int OP_MIN = -32768;
  localparam int OP_MAX = 32767;

  typedef struct {
    logic signed [RES_WIDTH-1:0] re;
    logic signed [RES_WIDTH-1:0] im;
    logic                        dz;
  } cplx_res_t;

  typedef struct {
    logic [1:0] op;
    int         ar, ai, br, bi;
    bit         typed;
    longint     er, ei;
    bit         edz;
  } corner_row_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [1:0]                  operation;
  logic signed [OW-1:0]        a_real, a_imag, b_real, b_imag;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [RES_WIDTH-1:0] res_real, res_imag;
  logic                        div_by_zero;

  cplx_res_t pending_results[$];
  int        mismatches;
  int        idle_cycles;
  int        op_count[4];
  int        zero_div_count;
  int        result_count;
  bit        stim_done;

  // expected values typed from the arithmetic where obvious
  corner_row_t corner_rows[NUM_DIRECTED] = '{
    '{OP_ADD, OP_MAX, OP_MAX, OP_MAX, OP_MAX, 1, 65534, 65534, 0},
    '{OP_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN, 1, -65536, -65536, 0},
    '{OP_SUB, OP_MIN, OP_MAX, OP_MAX, OP_MIN, 1, -65535, 65535, 0},
    '{OP_SUB, 0, 0, 0, 0, 1, 0, 0, 0},
    '{OP_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN, 1, 0, 64'sd2147483648, 0},
    '{OP_MUL, OP_MIN, 0, OP_MIN, 0, 1, 64'sd1073741824, 0, 0},
    '{OP_MUL, 0, OP_MIN, 0, OP_MAX, 1, 64'sd1073709056, 0, 0},
    '{OP_MUL, OP_MAX, OP_MIN, OP_MIN, OP_MAX, 0, 0, 0, 0},
    '{OP_DIV, 5, 7, 0, 0, 1, 0, 0, 1},
    '{OP_DIV, OP_MIN, OP_MIN, 0, 0, 1, 0, 0, 1},
    '{OP_DIV, 10, 0, 3, 0, 1, 3, 0, 0},
    '{OP_DIV, -7, 0, 2, 0, 1, -3, 0, 0},
    '{OP_DIV, 0, 7, 0, -2, 1, -3, 0, 0},
    '{OP_DIV, OP_MIN, OP_MIN, 1, 0, 1, -32768, -32768, 0},
    '{OP_DIV, OP_MAX, OP_MIN, OP_MIN, OP_MAX, 0, 0, 0, 0},
    '{OP_DIV, 1, 1, OP_MIN, OP_MIN, 1, 0, 0, 0}
  };

  complex_integer_alu #(.OPERAND_WIDTH(OW)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .a_real      (a_real),
    .a_imag      (a_imag),
    .b_real      (b_real),
    .b_imag      (b_imag),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res_real    (res_real),
    .res_imag    (res_imag),
    .div_by_zero (div_by_zero)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // exact gaussian integer arithmetic, quotient truncated toward zero
  function automatic cplx_res_t gauss_compute(logic [1:0] op, logic signed [OW-1:0] ar,
                                              logic signed [OW-1:0] ai,
                                              logic signed [OW-1:0] br,
                                              logic signed [OW-1:0] bi);
    cplx_res_t r;
    longint xr, xi, yr, yi, den;
    xr = ar;
    xi = ai;
    yr = br;
    yi = bi;
    r = '{re: '0, im: '0, dz: 1'b0};
    case (op)
      OP_ADD: begin
        r.re = RES_WIDTH'(xr + yr);
        r.im = RES_WIDTH'(xi + yi);
      end
      OP_SUB: begin
        r.re = RES_WIDTH'(xr - yr);
        r.im = RES_WIDTH'(xi - yi);
      end
      OP_MUL: begin
        r.re = RES_WIDTH'(xr * yr - xi * yi);
        r.im = RES_WIDTH'(xr * yi + xi * yr);
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = RES_WIDTH'((xr * yr + xi * yi) / den);
          r.im = RES_WIDTH'((xi * yr - xr * yi) / den);
        end
      end
    endcase
    return r;
  endfunction

  // random operand part biased toward the corners
  function automatic logic signed [OW-1:0] pick_part();
    case ($urandom_range(0, 9))
      0: return OW'(OP_MIN);
      1: return OW'(OP_MAX);
      2: return '0;
      3: return '1;
      4, 5: return OW'(int'($urandom_range(0, 20)) - 10);
      default: return OW'($urandom);
    endcase
  endfunction

  // drive one request and hold it until accepted
  task automatic send_request(logic [1:0] op, logic signed [OW-1:0] ar,
                              logic signed [OW-1:0] ai, logic signed [OW-1:0] br,
                              logic signed [OW-1:0] bi, bit typed, cplx_res_t typed_res);
    in_valid  <= 1'b1;
    operation <= op;
    a_real    <= ar;
    a_imag    <= ai;
    b_real    <= br;
    b_imag    <= bi;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_results.push_back(typed ? typed_res : gauss_compute(op, ar, ai, br, bi));
    op_count[op]++;
  endtask

  // stimulus: directed table, then random bursts
  initial begin
    int burst_left;
    int gap;
    logic [1:0] op;
    logic signed [OW-1:0] ar, ai, br, bi;
    cplx_res_t typed_res;
    rst       = 1'b1;
    in_valid  = 1'b0;
    operation = '0;
    a_real    = '0;
    a_imag    = '0;
    b_real    = '0;
    b_imag    = '0;
    stim_done = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (corner_rows[k]) begin
      typed_res = '{re: RES_WIDTH'(corner_rows[k].er), im: RES_WIDTH'(corner_rows[k].ei),
                    dz: corner_rows[k].edz};
      send_request(corner_rows[k].op, OW'(corner_rows[k].ar), OW'(corner_rows[k].ai),
                   OW'(corner_rows[k].br), OW'(corner_rows[k].bi), corner_rows[k].typed,
                   typed_res);
    end
    burst_left = $urandom_range(1, 30);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      op = 2'($urandom_range(0, 3));
      ar = pick_part();
      ai = pick_part();
      br = pick_part();
      bi = pick_part();
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        br = '0;
        bi = '0;
      end
      send_request(op, ar, ai, br, bi, 1'b0, typed_res);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d add, %0d sub, %0d mul, %0d div requests", op_count[OP_ADD],
             op_count[OP_SUB], op_count[OP_MUL], op_count[OP_DIV]);
    $display("%0d results checked, %0d zero-divisor results, %0d mismatches",
             result_count, zero_div_count, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("complex_integer_alu regression: pass");
    end else begin
      $display("complex_integer_alu regression: fail");
    end
    $finish;
  end

  // receiver stall pattern: random modes, from always ready to mostly stalled
  initial begin
    int mode;
    out_ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat (64) begin
        @(posedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= $urandom_range(0, 7) == 0;
          default: out_ready <= $urandom_range(0, 7) != 0;
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    cplx_res_t want;
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (div_by_zero) zero_div_count++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result re=%0d im=%0d dz=%0b",
                                       res_real, res_imag, div_by_zero);
      end else begin
        want = pending_results.pop_front();
        if (res_real !== want.re || res_imag !== want.im || div_by_zero !== want.dz) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected re=%0d im=%0d dz=%0b, got re=%0d im=%0d dz=%0b",
                     want.re, want.im, want.dz, res_real, res_imag, div_by_zero);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (stim_done && pending_results.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("complex_integer_alu regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    mismatches     = 0;
    idle_cycles    = 0;
    zero_div_count = 0;
    result_count   = 0;
    foreach (op_count[k]) op_count[k] = 0;
  end

endmodule
